FILE: hdl/double_ended_queue_unit_defines.svh
// Assertion macros for the double-ended queue unit
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");
`else
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 5;

    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_POP_FRONT  = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_BACK,
        CMD_PUSH_FRONT,
        CMD_POP_BACK,
        CMD_POP_FRONT,
        CMD_CLEAR
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              valid;
    } link_t;

endpackage

FILE: hdl/double_ended_queue_unit.sv
// Bounded deque of 16 signed 32-bit words, held in a row of cells with the
// front word in the first cell. A request is taken whenever start is high
// and busy is low; busy stays low, so one request can follow another in
// every cycle. Each request gives exactly one result, shown for one cycle
// with done high in the cycle right after the request was taken. The
// receiver cannot stall: it must take each result in the cycle it appears.
// A pop of an empty deque reports underflow, a push into a full deque is
// dropped and reports overflow.
`include "double_ended_queue_unit_defines.svh"

module double_ended_queue_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  opcode,
    input  logic signed [deq_pkg::WORD_W-1:0] push_word,
    output logic                        done,
    output logic signed [deq_pkg::WORD_W-1:0] popped_word,
    output logic signed [deq_pkg::WORD_W-1:0] front_word,
    output logic signed [deq_pkg::WORD_W-1:0] back_word,
    output logic [deq_pkg::CNT_W-1:0]   element_count,
    output logic                        is_empty,
    output logic [1:0]                  status
);
    import deq_pkg::*;

    link_t             left_link [DEPTH];
    link_t             right_link[DEPTH];
    link_t             cell_link [DEPTH];
    logic [DEPTH-1:0]  cell_valid;
    logic [WORD_W-1:0] back_sel;

    cmd_t              cmd;
    logic              accept;
    logic              full;
    logic              empty;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WORD_W-1:0] popped_reg;
    logic [WORD_W-1:0] popped_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign left_link[gi].word  = push_word;
                assign left_link[gi].valid = 1'b1;
            end
            else
            begin : g_mid
                assign left_link[gi] = cell_link[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_link[gi].word  = '0;
                assign right_link[gi].valid = 1'b0;
            end
            else
            begin : g_inner
                assign right_link[gi] = cell_link[gi+1];
            end
            assign cell_valid[gi] = cell_link[gi].valid;

            deq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .push_word (push_word),
                .left      (left_link[gi]),
                .right     (right_link[gi]),
                .own       (cell_link[gi])
            );
        end
    endgenerate

    // pick the word of the last occupied cell
    always_comb
    begin
        back_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_link[i].valid && !right_link[i].valid)
            begin
                back_sel = back_sel | cell_link[i].word;
            end
        end
    end

    always_comb
    begin
        cmd         = CMD_HOLD;
        status_next = ST_OK;
        popped_next = '1;
        count_next  = count_reg;
        if (accept)
        begin
            case (opcode)
                OP_PUSH_BACK, OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd        = (opcode == OP_PUSH_BACK) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_BACK, OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = ST_UNDERFLOW;
                    end
                    else
                    begin
                        cmd         = (opcode == OP_POP_BACK) ? CMD_POP_BACK : CMD_POP_FRONT;
                        popped_next = (opcode == OP_POP_BACK) ? back_sel : cell_link[0].word;
                        count_next  = count_reg - 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    cmd        = CMD_CLEAR;
                    count_next = '0;
                end
                default:
                begin
                    cmd = CMD_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
    end

    assign done          = done_reg;
    assign popped_word   = popped_reg;
    assign status        = status_reg;
    assign element_count = count_reg;
    assign is_empty      = empty;
    assign front_word    = cell_link[0].valid ? cell_link[0].word : '1;
    assign back_word     = cell_link[0].valid ? back_sel : '1;

    `DEQ_ASSERT_IMP(a_count_match, clk, rst_n, 1'b1, $countones(cell_valid) == count_reg)
    `DEQ_ASSERT_IMP(a_empty_front, clk, rst_n, 1'b1, empty == !cell_valid[0])
    `DEQ_ASSERT_NXT(a_done_follows, clk, rst_n, accept, done)
    `DEQ_ASSERT_NXT(a_underflow, clk, rst_n, accept && empty && (opcode == OP_POP_BACK || opcode == OP_POP_FRONT), status == ST_UNDERFLOW && is_empty)

endmodule

FILE: hdl/deq_cell.sv
module deq_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  deq_pkg::cmd_t cmd,
    input  logic [deq_pkg::WORD_W-1:0] push_word,
    input  deq_pkg::link_t left,
    input  deq_pkg::link_t right,
    output deq_pkg::link_t own
);
    import deq_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              valid_reg;
    logic              valid_next;

    always_comb
    begin
        word_next  = word_reg;
        valid_next = valid_reg;
        case (cmd)
            CMD_PUSH_BACK:
            begin
                if (left.valid && !valid_reg)
                begin
                    word_next  = push_word;
                    valid_next = 1'b1;
                end
            end
            CMD_PUSH_FRONT:
            begin
                word_next  = left.word;
                valid_next = left.valid;
            end
            CMD_POP_BACK:
            begin
                if (valid_reg && !right.valid)
                begin
                    valid_next = 1'b0;
                end
            end
            CMD_POP_FRONT:
            begin
                word_next  = right.word;
                valid_next = right.valid;
            end
            CMD_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                word_next  = word_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign own.word  = word_reg;
    assign own.valid = valid_reg;

endmodule

FILE: dv/double_ended_queue_checker.sv
`timescale 1ns / 100ps

module double_ended_queue_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [2:0]                        opcode,
    input  logic signed [deq_pkg::WORD_W-1:0] push_word,
    input  logic                              done,
    input  logic signed [deq_pkg::WORD_W-1:0] popped_word,
    input  logic signed [deq_pkg::WORD_W-1:0] front_word,
    input  logic signed [deq_pkg::WORD_W-1:0] back_word,
    input  logic [deq_pkg::CNT_W-1:0]         element_count,
    input  logic                              is_empty,
    input  logic [1:0]                        status,
    output int                                mismatch_count,
    output int                                pending
);
    import deq_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] popped;
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] back;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic [1:0]        status;
    } deq_view_t;

    logic [WORD_W-1:0] ring [DEPTH];
    logic [3:0]        head_idx;
    logic [CNT_W-1:0]  fill;
    deq_view_t         expected_views[$];
    int                mismatches;

    assign mismatch_count = mismatches;

    function automatic deq_view_t apply_request(input logic [2:0] op,
                                                input logic [WORD_W-1:0] word);
        deq_view_t  view;
        logic [3:0] slot;
        view.popped = '1;
        view.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (fill == DEPTH)
                begin
                    view.status = ST_OVERFLOW;
                end
                else if (op == OP_PUSH_BACK)
                begin
                    slot = head_idx + fill[3:0];
                    ring[slot] = word;
                    fill = fill + 1'b1;
                end
                else
                begin
                    head_idx = head_idx - 1'b1;
                    ring[head_idx] = word;
                    fill = fill + 1'b1;
                end
            end
            OP_POP_BACK, OP_POP_FRONT:
            begin
                if (fill == 0)
                begin
                    view.status = ST_UNDERFLOW;
                end
                else if (op == OP_POP_BACK)
                begin
                    slot = head_idx + fill[3:0] - 1'b1;
                    view.popped = ring[slot];
                    fill = fill - 1'b1;
                end
                else
                begin
                    view.popped = ring[head_idx];
                    head_idx = head_idx + 1'b1;
                    fill = fill - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                head_idx = '0;
                fill = '0;
            end
            default:
            begin
            end
        endcase
        if (fill == 0)
        begin
            view.front = '1;
            view.back  = '1;
        end
        else
        begin
            slot = head_idx + fill[3:0] - 1'b1;
            view.front = ring[head_idx];
            view.back  = ring[slot];
        end
        view.count = fill;
        view.empty = (fill == 0);
        return view;
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deq_view_t want;
        if (!rst_n)
        begin
            head_idx = '0;
            fill = '0;
            expected_views.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_views.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with no request outstanding", $time);
                    mismatches++;
                end
                else
                begin
                    want = expected_views[0];
                    expected_views.delete(0);
                    check_field("popped_word", want.popped, popped_word);
                    check_field("front_word", want.front, front_word);
                    check_field("back_word", want.back, back_word);
                    check_field("element_count", WORD_W'(want.count),
                                WORD_W'(element_count));
                    check_field("is_empty", WORD_W'(want.empty), WORD_W'(is_empty));
                    check_field("status", WORD_W'(want.status), WORD_W'(status));
                end
            end
            if (start && !busy)
                expected_views.insert(expected_views.size(), apply_request(opcode, push_word));
            pending <= expected_views.size();
        end
    end

endmodule

FILE: dv/double_ended_queue_unit_test.sv
`timescale 1ns / 100ps

module double_ended_queue_unit_test;
    import deq_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int RANDOM_REQUESTS = 1650;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               opcode;
    logic signed [WORD_W-1:0] push_word;
    logic                     done;
    logic signed [WORD_W-1:0] popped_word;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;
    logic [CNT_W-1:0]         element_count;
    logic                     is_empty;
    logic [1:0]               status;
    int                       mismatch_count;
    int                       pending;

    double_ended_queue_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .push_word     (push_word),
        .done          (done),
        .popped_word   (popped_word),
        .front_word    (front_word),
        .back_word     (back_word),
        .element_count (element_count),
        .is_empty      (is_empty),
        .status        (status)
    );

    double_ended_queue_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .push_word      (push_word),
        .done           (done),
        .popped_word    (popped_word),
        .front_word     (front_word),
        .back_word      (back_word),
        .element_count  (element_count),
        .is_empty       (is_empty),
        .status         (status),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return '0;
            4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_op(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return OP_CLEAR;
        if (roll < 6)
        begin
            case ($urandom_range(0, 2))
                0: return OP_NONE;
                1: return OP_SPARE_A;
                default: return OP_SPARE_B;
            endcase
        end
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [WORD_W-1:0] word,
                                input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        push_word <= word;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int         sent;
        int         seg_left;
        int         push_pct;
        bit         idle_on;
        bit         drained;
        logic [2:0] op;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        opcode    <= OP_NONE;
        push_word <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque, ignored opcodes, extreme words
        send_request(OP_POP_FRONT, pick_word(), $urandom_range(0, 11));
        send_request(OP_POP_BACK, pick_word(), 0);
        send_request(OP_NONE, pick_word(), 0);
        send_request(OP_SPARE_A, pick_word(), $urandom_range(0, 11));
        send_request(OP_SPARE_B, pick_word(), 0);
        send_request(OP_PUSH_BACK, 32'h8000_0000, 0);
        send_request(OP_PUSH_FRONT, 32'h7fff_ffff, $urandom_range(0, 11));
        send_request(OP_PUSH_BACK, '1, 0);
        send_request(OP_PUSH_FRONT, '0, 0);
        // fill to the top, then overflow both ends
        for (int i = 0; i < 12; i++)
            send_request(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word(), 0);
        send_request(OP_PUSH_BACK, pick_word(), $urandom_range(0, 11));
        send_request(OP_PUSH_FRONT, pick_word(), 0);
        send_request(OP_POP_BACK, pick_word(), 0);
        send_request(OP_POP_FRONT, pick_word(), 0);
        send_request(OP_CLEAR, pick_word(), 0);

        sent     = 0;
        seg_left = 0;
        push_pct = 50;
        idle_on  = 1'b0;
        drained  = 1'b0;
        while (sent < RANDOM_REQUESTS)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0: push_pct = 75;
                    1: push_pct = 25;
                    default: push_pct = 50;
                endcase
                idle_on = ($urandom_range(0, 3) != 0);
            end
            seg_left--;
            op = pick_op(push_pct);
            send_request(op, pick_word(), idle_on ? $urandom_range(0, 11) : 0);
            sent++;
            if (!drained && sent >= RANDOM_REQUESTS / 2)
            begin
                wait_drained();
                drained = 1'b1;
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/double_ended_queue_unit.sv
dv/double_ended_queue_checker.sv
dv/double_ended_queue_unit_test.sv
